// File: rtl/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 9;

  localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 9'd16;

  // item kind codes
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,   // S[a] = a sweep
    ST_KRA,    // schedule: read S[a]
    ST_KRB,    // schedule: update b, read S[b]
    ST_KWA,    // schedule: S[a] = old S[b]
    ST_KWB,    // schedule: S[b] = old S[a]
    ST_DRJ,    // data: update j, read S[j]
    ST_DWI,    // data: S[i] = S[j], read S[S[i]+S[j]]
    ST_DWJ,    // data: S[j] = S[i], form output word
    ST_EMIT    // output word waits for a free slot
  } rc4_state_e;

  typedef struct packed {
    logic restart;   // key read pointer back to zero
    logic advance;   // key read pointer to next byte, mod length
  } rc4_key_ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              keyed;
  } rc4_res_t;

endpackage

// File: rtl/rc4_if.sv
interface rc4_in_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] value;
  logic              in_last;

  modport source (output valid, kind, value, in_last, input ready);
  modport sink   (input valid, kind, value, in_last, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic              out_last;
  logic              keyed;

  modport source (output valid, data_out, out_last, keyed, input ready);
  modport sink   (input valid, data_out, out_last, keyed, output ready);
endinterface

interface rc4_cfg_if import rc4_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] key_length;

  modport source (output valid, key_length, input ready);
  modport sink   (input valid, key_length, output ready);
endinterface

// File: rtl/rc4_key_store.sv
module rc4_key_store import rc4_pkg::*; #(
  parameter int unsigned KEY_STORE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [BYTE_W-1:0] wr_data_i,
  input  logic              keyed_i,
  input  logic [LEN_W-1:0]  len_i,
  input  rc4_key_ctl_t      ctl_i,
  output logic              sched_go_o,
  output logic [BYTE_W-1:0] key_byte_o
);

  localparam int unsigned KW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
  localparam logic [LEN_W-1:0] DEPTH_C = LEN_W'(KEY_STORE_DEPTH);

  logic [BYTE_W-1:0] mem [KEY_STORE_DEPTH];

  logic [LEN_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  ptr_q, ptr_d;
  logic [BYTE_W-1:0] key_byte_q;

  logic [LEN_W-1:0] base;
  logic [LEN_W-1:0] count_after;
  logic [LEN_W-1:0] ptr_inc;
  logic             room;

  // a key byte after keying restarts the load at position zero
  assign base        = keyed_i ? '0 : count_q;
  assign room        = (base < DEPTH_C);
  assign count_after = base + {{(LEN_W-1){1'b0}}, room};
  assign sched_go_o  = (count_after >= len_i);
  assign ptr_inc     = ptr_q + LEN_W'(1);

  always_comb begin
    count_d = count_q;
    if (wr_en_i) begin
      count_d = sched_go_o ? '0 : count_after;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.restart) begin
      ptr_d = '0;
    end else if (ctl_i.advance) begin
      ptr_d = (ptr_inc == len_i) ? '0 : ptr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && room) begin
      mem[base[KW-1:0]] <= wr_data_i;
    end
    key_byte_q <= mem[ptr_q[KW-1:0]];
  end

  assign key_byte_o = key_byte_q;

endmodule

// File: rtl/rc4_core.sv
module rc4_core import rc4_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              kind_i,
  input  logic [BYTE_W-1:0] value_i,
  input  logic              last_i,
  input  logic              sched_go_i,
  input  logic [BYTE_W-1:0] key_byte_i,
  input  logic              slot_free_i,
  output logic              idle_o,
  output logic              keyed_o,
  output rc4_key_ctl_t      key_ctl_o,
  output logic              emit_o,
  output rc4_res_t          res_o
);

  localparam logic [BYTE_W-1:0] LAST_IDX = '1;

  logic [BYTE_W-1:0] sbox [256];
  logic [BYTE_W-1:0] s_rdata_q;
  logic              s_we;
  logic [BYTE_W-1:0] s_waddr, s_wdata, s_raddr;

  rc4_state_e state_q, state_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;
  logic [BYTE_W-1:0] b_q, b_d;
  logic [BYTE_W-1:0] i_q, i_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] si_q, si_d;
  logic [BYTE_W-1:0] sj_q, sj_d;
  logic              t_is_i_q, t_is_i_d;
  logic              t_is_j_q, t_is_j_d;
  logic              keyed_q, keyed_d;
  rc4_res_t          res_q, res_d;

  logic [BYTE_W-1:0] b_new, j_new, t_idx, i_next, ks;
  logic              is_key;

  assign is_key = (kind_i == KIND_KEY);
  assign i_next = i_q + BYTE_W'(1);
  assign b_new  = b_q + s_rdata_q + key_byte_i;
  assign j_new  = j_q + s_rdata_q;
  assign t_idx  = si_q + s_rdata_q;
  // S[t] is read before the S[i] and S[j] writes land, so take it from the swap
  assign ks     = t_is_j_q ? si_q : (t_is_i_q ? sj_q : s_rdata_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (is_key) begin
            state_d = sched_go_i ? ST_INIT : ST_IDLE;
          end else begin
            state_d = keyed_q ? ST_DRJ : ST_EMIT;
          end
        end
      end
      ST_INIT: if (cnt_q == LAST_IDX) state_d = ST_KRA;
      ST_KRA:  state_d = ST_KRB;
      ST_KRB:  state_d = ST_KWA;
      ST_KWA:  state_d = ST_KWB;
      ST_KWB:  state_d = (cnt_q == LAST_IDX) ? ST_IDLE : ST_KRA;
      ST_DRJ:  state_d = ST_DWI;
      ST_DWI:  state_d = ST_DWJ;
      ST_DWJ:  state_d = slot_free_i ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (slot_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_we      = 1'b0;
    s_waddr   = cnt_q;
    s_wdata   = cnt_q;
    s_raddr   = i_next;
    key_ctl_o = '0;
    emit_o    = 1'b0;
    res_o     = res_q;
    case (state_q)
      ST_IDLE: begin
        key_ctl_o.restart = start_i && is_key && sched_go_i;
      end
      ST_INIT: begin
        s_we = 1'b1;
      end
      ST_KRA: begin
        s_raddr = cnt_q;
      end
      ST_KRB: begin
        s_raddr = b_new;
      end
      ST_KWA: begin
        s_we    = 1'b1;
        s_wdata = s_rdata_q;
      end
      ST_KWB: begin
        s_we              = 1'b1;
        s_waddr           = b_q;
        s_wdata           = si_q;
        key_ctl_o.advance = 1'b1;
      end
      ST_DRJ: begin
        s_raddr = j_new;
      end
      ST_DWI: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata_q;
        s_raddr = t_idx;
      end
      ST_DWJ: begin
        s_we       = 1'b1;
        s_waddr    = j_q;
        s_wdata    = si_q;
        emit_o     = slot_free_i;
        res_o.data = res_q.data ^ ks;
      end
      ST_EMIT: begin
        emit_o = slot_free_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    b_d      = b_q;
    i_d      = i_q;
    j_d      = j_q;
    si_d     = si_q;
    sj_d     = sj_q;
    t_is_i_d = t_is_i_q;
    t_is_j_d = t_is_j_q;
    keyed_d  = keyed_q;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (is_key) begin
            keyed_d = 1'b0;
            cnt_d   = '0;
          end else begin
            res_d.data  = value_i;
            res_d.last  = last_i;
            res_d.keyed = keyed_q;
            if (keyed_q) begin
              i_d = i_next;
            end
          end
        end
      end
      ST_INIT: begin
        cnt_d = cnt_q + BYTE_W'(1);
        b_d   = '0;
      end
      ST_KRB: begin
        b_d  = b_new;
        si_d = s_rdata_q;
      end
      ST_KWB: begin
        cnt_d = cnt_q + BYTE_W'(1);
        if (cnt_q == LAST_IDX) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
        end
      end
      ST_DRJ: begin
        si_d = s_rdata_q;
        j_d  = j_new;
      end
      ST_DWI: begin
        sj_d     = s_rdata_q;
        t_is_i_d = (t_idx == i_q);
        t_is_j_d = (t_idx == j_q);
      end
      ST_DWJ: begin
        res_d.data = res_q.data ^ ks;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      keyed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      keyed_q <= keyed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    b_q      <= b_d;
    si_q     <= si_d;
    sj_q     <= sj_d;
    t_is_i_q <= t_is_i_d;
    t_is_j_q <= t_is_j_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      sbox[s_waddr] <= s_wdata;
    end
    s_rdata_q <= sbox[s_raddr];
  end

  assign idle_o  = (state_q == ST_IDLE);
  assign keyed_o = keyed_q;

endmodule

// File: rtl/rc4_stream_cipher.sv
// RC4 stream cipher with valid/ready word channels. Write key_length on the
// config channel (reset 16, zero acts as 1, values above KEY_STORE_DEPTH are
// clipped), then send key words (kind 0), then data words (kind 1). Key words
// are taken back to back; the word that completes the key starts the schedule,
// during which input ready stays low: a sweep loads the S-box identity, then
// 256 steps, each reading S[a] and S[b] and writing both back. Once keyed, each
// data word goes through the accept state and three S-box access states, set
// by the S-box memory with one read and one write port. Before keying, data
// words pass through the emit state and come out unchanged with keyed low. A
// key word after keying drops keyed and restarts the key load. A result waiting
// in the output register only holds the core once the next result is ready.
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int unsigned KEY_STORE_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rc4_in_if.sink   in_i,
  rc4_out_if.source out_o,
  rc4_cfg_if.sink  cfg_i
);

  localparam logic [LEN_W-1:0] DEPTH_C = LEN_W'(KEY_STORE_DEPTH);

  // config register and its effective value
  logic [LEN_W-1:0] key_length_q, key_length_d;
  logic [LEN_W-1:0] len_eff;

  assign cfg_i.ready  = 1'b1;
  assign key_length_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.key_length : key_length_q;

  always_comb begin
    if (key_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_length_q > DEPTH_C) begin
      len_eff = DEPTH_C;
    end else begin
      len_eff = key_length_q;
    end
  end

  // input side
  logic         core_idle;
  logic         accept;
  logic         keyed;
  logic         sched_go;
  logic [BYTE_W-1:0] key_byte;
  rc4_key_ctl_t key_ctl;

  assign in_i.ready = core_idle;
  assign accept     = in_i.valid && in_i.ready;

  // output register: one word slot between core and sink
  logic      out_valid_q, out_valid_d;
  rc4_res_t  out_q, out_d;
  logic      slot_free;
  logic      emit;
  rc4_res_t  res;

  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LENGTH_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      key_length_q <= key_length_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_q.data;
  assign out_o.out_last = out_q.last;
  assign out_o.keyed    = out_q.keyed;

  rc4_key_store #(
    .KEY_STORE_DEPTH(KEY_STORE_DEPTH)
  ) u_key_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept && (in_i.kind == KIND_KEY)),
    .wr_data_i  (in_i.value),
    .keyed_i    (keyed),
    .len_i      (len_eff),
    .ctl_i      (key_ctl),
    .sched_go_o (sched_go),
    .key_byte_o (key_byte)
  );

  rc4_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .kind_i      (in_i.kind),
    .value_i     (in_i.value),
    .last_i      (in_i.in_last),
    .sched_go_i  (sched_go),
    .key_byte_i  (key_byte),
    .slot_free_i (slot_free),
    .idle_o      (core_idle),
    .keyed_o     (keyed),
    .key_ctl_o   (key_ctl),
    .emit_o      (emit),
    .res_o       (res)
  );

endmodule

// File: test/tb_rc4_stream_cipher.sv
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int unsigned KEY_DEPTH = 256;
  // Longest core busy time: the S-box sweep plus the 256 schedule steps.
  // Padded so a pending schedule is done before key_length changes.
  localparam int unsigned SETTLE_CYCLES = 1400;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  rc4_in_if  in_bus ();
  rc4_out_if out_bus ();
  rc4_cfg_if cfg_bus ();

  rc4_stream_cipher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher state mirror. Updated at the edge where each word is accepted.
  // ---------------------------------------------------------------------------
  logic [7:0]       s_box     [KEY_DEPTH];
  logic [7:0]       key_bytes [KEY_DEPTH];
  logic [7:0]       ks_i;
  logic [7:0]       ks_j;
  int unsigned      key_fill;
  logic             keyed_now;
  logic [LEN_W-1:0] key_len_reg;

  // Result words still owed by the block, oldest first.
  rc4_res_t cipher_words [$];
  rc4_res_t head_word;

  int send_idle_pct;
  int sink_stall_pct;
  int fail_count = 0;
  int unsigned cycle_count = 0;

  // Zero acts as one; anything past the store depth is clipped.
  function automatic int unsigned effective_key_len(input logic [LEN_W-1:0] reg_val);
    if (reg_val == '0) return 1;
    if (reg_val > LEN_W'(KEY_DEPTH)) return KEY_DEPTH;
    return 32'(reg_val);
  endfunction

  function automatic void run_key_schedule(input int unsigned len);
    logic [7:0] b;
    logic [7:0] tmp;
    b = 8'd0;
    for (int a = 0; a < 256; a++) s_box[a] = a[7:0];
    for (int a = 0; a < 256; a++) begin
      b = b + s_box[a] + key_bytes[a % len];
      tmp = s_box[a];
      s_box[a] = s_box[b];
      s_box[b] = tmp;
    end
    ks_i = 8'd0;
    ks_j = 8'd0;
    keyed_now = 1'b1;
  endfunction

  function automatic logic [7:0] next_keystream_byte();
    logic [7:0] tmp;
    logic [7:0] sum;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + s_box[ks_i];
    tmp = s_box[ks_i];
    s_box[ks_i] = s_box[ks_j];
    s_box[ks_j] = tmp;
    sum = s_box[ks_i] + s_box[ks_j];
    return s_box[sum];
  endfunction

  function automatic void rc4_apply_word(input logic kind, input logic [7:0] value,
                                         input logic last);
    int unsigned len;
    rc4_res_t word;
    if (kind == KIND_KEY) begin
      len = effective_key_len(key_len_reg);
      // key word on a keyed core starts a fresh load
      if (keyed_now) begin
        keyed_now = 1'b0;
        key_fill = 0;
      end
      if (key_fill < KEY_DEPTH) begin
        key_bytes[key_fill] = value;
        key_fill++;
      end
      if (key_fill >= len) begin
        run_key_schedule(len);
        key_fill = 0;
      end
    end else begin
      word.last = last;
      if (keyed_now) begin
        word.data  = value ^ next_keystream_byte();
        word.keyed = 1'b1;
      end else begin
        word.data  = value;
        word.keyed = 1'b0;
      end
      cipher_words.push_back(word);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and result check.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (cipher_words.size() == 0) begin
        $error("result word with none pending: data_out=%02h out_last=%0b keyed=%0b",
               out_bus.data_out, out_bus.out_last, out_bus.keyed);
        fail_count++;
      end else begin
        head_word = cipher_words.pop_front();
        if (out_bus.data_out !== head_word.data) begin
          $error("data_out: expected %02h, actual %02h", head_word.data, out_bus.data_out);
          fail_count++;
        end
        if (out_bus.out_last !== head_word.last) begin
          $error("out_last: expected %0b, actual %0b", head_word.last, out_bus.out_last);
          fail_count++;
        end
        if (out_bus.keyed !== head_word.keyed) begin
          $error("keyed: expected %0b, actual %0b", head_word.keyed, out_bus.keyed);
          fail_count++;
        end
      end
    end
  end

  // Hung handshake guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // valid is only dropped when a gap follows, so back-to-back words never see
  // a low/high pair in one step.
  task automatic send_word(input logic kind, input logic [7:0] value, input logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid   <= 1'b1;
    in_bus.kind    <= kind;
    in_bus.value   <= value;
    in_bus.in_last <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    rc4_apply_word(kind, value, last);
  endtask

  // Drain all owed words, then let a running key schedule finish.
  task automatic settle_core();
    in_bus.valid <= 1'b0;
    while (cipher_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_key_length(input logic [LEN_W-1:0] len);
    settle_core();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.key_length <= len;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    key_len_reg = len;
  endtask

  task automatic send_key_run(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_word(KIND_KEY, 8'($urandom_range(255)), 1'b0);
  endtask

  // Message of count data words, last flag on the final one.
  task automatic send_message(input int unsigned count);
    for (int unsigned n = 0; n < count; n++)
      send_word(KIND_DATA, 8'($urandom_range(255)), n == count - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Unkeyed core: data comes back unchanged, keyed low.
  task automatic test_passthrough();
    send_word(KIND_DATA, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'hff, 1'b1);
    send_word(KIND_DATA, 8'h5a, 1'b0);
  endtask

  // Key length out of reset is 16.
  task automatic test_reset_key_length();
    send_key_run(16);
    send_message(3);
  endtask

  // Length zero behaves as a one-byte key.
  task automatic test_key_length_zero();
    write_key_length('0);
    send_word(KIND_KEY, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'hff, 1'b1);
  endtask

  // Key word on a keyed core drops keyed; data mid-load passes through.
  task automatic test_rekey_restart();
    write_key_length(LEN_W'(2));
    send_word(KIND_KEY, 8'hff, 1'b0);
    send_word(KIND_DATA, 8'h33, 1'b1);
    send_word(KIND_KEY, 8'h80, 1'b0);
    send_word(KIND_DATA, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'hff, 1'b1);
  endtask

  // Shorter length written mid-load: the next key word triggers the schedule.
  task automatic test_length_lowered();
    write_key_length(LEN_W'(4));
    send_word(KIND_KEY, 8'h01, 1'b0);
    send_word(KIND_KEY, 8'h02, 1'b0);
    send_word(KIND_KEY, 8'h03, 1'b0);
    write_key_length(LEN_W'(2));
    send_word(KIND_KEY, 8'h04, 1'b0);
    send_word(KIND_DATA, 8'hc3, 1'b1);
  endtask

  // Register at its top value, clipped to a full-depth key; then a one-byte key.
  task automatic test_long_keys();
    write_key_length('1);
    send_key_run(256);
    send_message(4);
    write_key_length(LEN_W'(1));
    send_key_run(1);
    send_message(4);
  endtask

  // Mostly key-then-message sessions; some cut-short loads and loose words.
  task automatic test_random_traffic(input int n_words, input int idle_pct,
                                     input int stall_pct);
    int          sent;
    int          roll;
    int unsigned len;
    int unsigned n_keys;
    int unsigned n_data;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 30) begin
        // short lengths keep schedules cheap and the word count bounded
        write_key_length(LEN_W'($urandom_range(16, 1)));
      end
      len  = effective_key_len(key_len_reg);
      roll = $urandom_range(99);
      if (roll < 80) begin
        n_keys = keyed_now ? len : ((len > key_fill) ? len - key_fill : 1);
        n_data = $urandom_range(24, 1);
        send_key_run(n_keys);
        send_message(n_data);
        sent += n_keys + n_data;
      end else if (roll < 90) begin
        // load cut short: data in between goes out unkeyed
        n_keys = (len > 1) ? $urandom_range(len - 1, 1) : 1;
        n_data = $urandom_range(6, 1);
        send_key_run(n_keys);
        send_message(n_data);
        sent += n_keys + n_data;
      end else begin
        n_data = $urandom_range(8, 1);
        for (int unsigned n = 0; n < n_data; n++)
          send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent += n_data;
      end
    end
    settle_core();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.kind        <= KIND_KEY;
    in_bus.value       <= 8'h00;
    in_bus.in_last     <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.key_length <= KEY_LENGTH_RESET;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    key_len_reg    = KEY_LENGTH_RESET;
    key_fill       = 0;
    keyed_now      = 1'b0;
    ks_i           = 8'd0;
    ks_j           = 8'd0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_reset_key_length();
    test_key_length_zero();
    test_rekey_restart();
    test_length_lowered();
    test_long_keys();
    test_random_traffic(40, 29, 70);
    test_random_traffic(40, 70, 29);
    test_random_traffic(40, 0, 0);

    settle_core();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rc4_pkg.sv
rtl/rc4_if.sv
rtl/rc4_key_store.sv
rtl/rc4_core.sv
rtl/rc4_stream_cipher.sv
test/tb_rc4_stream_cipher.sv
